// File: design/fresnel_reflectance_unit_assert.svh
// Assertion macros for the Fresnel reflectance unit.
// Needs a clock named clk and a reset named rst in the module that uses them.
`ifndef FRESNEL_REFLECTANCE_UNIT_ASSERT_SVH
`define FRESNEL_REFLECTANCE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FRU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assert failed");
`define FRU_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assert failed");
`else
`define FRU_ASSERT(lbl, prop)
`define FRU_ASSERT_RST(lbl, prop)
`endif
`endif

// File: design/fru_pkg.sv
// Shared types and constants of the Fresnel reflectance unit.
// No dependencies.
package fru_pkg;
  localparam int DivSteps = 31;
  localparam logic [16:0] ONE_OUT = 17'h10000;
  localparam logic [15:0] ONE_ETA = 16'd4096;
  localparam logic [14:0] ONE_COS = 15'd16384;

  typedef enum logic [1:0] {
    FUNC_DIEL_TWO   = 2'd0,
    FUNC_DIEL_RATIO = 2'd1,
    FUNC_COND       = 2'd2,
    FUNC_COND_FULL  = 2'd3
  } func_t;

  typedef struct packed {
    logic valid;
    logic dielectric;
    logic degen;
  } ctl_t;
endpackage

// File: design/fru_front.sv
// Front stages: products, sums and the numerator/denominator of both terms.
// Depends on fru_pkg.
module fru_front import fru_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        enable,
  input  logic        in_valid,
  input  logic [1:0]  func,
  input  logic [14:0] cos_incident,
  input  logic [14:0] cos_transmitted,
  input  logic [15:0] eta_value,
  input  logic [15:0] eta_incident,
  input  logic [15:0] extinction,
  output ctl_t        ctl,
  output logic [63:0] num_p,
  output logic [63:0] den_p,
  output logic [63:0] num_q,
  output logic [63:0] den_q
);
  logic [15:0] ei;
  logic [14:0] ct_eff;
  logic        diel_in;

  always_comb begin
    diel_in = (func_t'(func) == FUNC_DIEL_TWO) || (func_t'(func) == FUNC_DIEL_RATIO);
    ei = (func_t'(func) == FUNC_DIEL_RATIO) ? ONE_ETA : eta_incident;
    ct_eff = (func_t'(func) == FUNC_COND) ? ONE_COS : cos_transmitted;
  end

  // stage 1
  logic        v1, diel1, eiz1;
  logic [30:0] a1, b1, c1, d1;
  logic [31:0] ev2_1, kk2_1;
  logic [29:0] ci2_1, ct2_1;
  logic [14:0] ct1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (enable) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      diel1 <= diel_in;
      eiz1  <= (ei == 16'd0);
      a1    <= 31'(ei) * 31'(ct_eff);
      b1    <= 31'(eta_value) * 31'(cos_incident);
      c1    <= 31'(ei) * 31'(cos_incident);
      d1    <= 31'(eta_value) * 31'(ct_eff);
      ev2_1 <= 32'(eta_value) * 32'(eta_value);
      kk2_1 <= 32'(extinction) * 32'(extinction);
      ci2_1 <= 30'(cos_incident) * 30'(cos_incident);
      ct2_1 <= 30'(ct_eff) * 30'(ct_eff);
      ct1   <= ct_eff;
    end
  end

  // stage 2
  logic        v2, diel2, eiz2;
  logic [32:0] s2;
  logic [29:0] ci2_2, ct2_2;
  logic [45:0] t2;
  logic [30:0] np2, nq2;
  logic [31:0] dp2, dq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (enable) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      diel2 <= diel1;
      eiz2  <= eiz1;
      s2    <= 33'(ev2_1) + 33'(kk2_1);
      ci2_2 <= ci2_1;
      ct2_2 <= ct2_1;
      t2    <= 46'(b1) * 46'(ct1);
      np2   <= (a1 >= b1) ? a1 - b1 : b1 - a1;
      nq2   <= (c1 >= d1) ? c1 - d1 : d1 - c1;
      dp2   <= 32'(a1) + 32'(b1);
      dq2   <= 32'(c1) + 32'(d1);
    end
  end

  // stage 3: split s so every product stays near 17 x 30
  logic        v3, diel3, eiz3;
  logic [46:0] lo_ci3, lo_ct3;
  logic [45:0] hi_ci3, hi_ct3;
  logic [29:0] ci2_3, ct2_3;
  logic [58:0] t3;
  logic [30:0] np3, nq3;
  logic [31:0] dp3, dq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (enable) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      diel3  <= diel2;
      eiz3   <= eiz2;
      lo_ci3 <= 47'(s2[16:0]) * 47'(ci2_2);
      lo_ct3 <= 47'(s2[16:0]) * 47'(ct2_2);
      hi_ci3 <= 46'(s2[32:17]) * 46'(ci2_2);
      hi_ct3 <= 46'(s2[32:17]) * 46'(ct2_2);
      ci2_3  <= ci2_2;
      ct2_3  <= ct2_2;
      t3     <= {t2, 13'd0};
      np3    <= np2;
      nq3    <= nq2;
      dp3    <= dp2;
      dq3    <= dq2;
    end
  end

  // stage 4
  logic        v4, diel4, eiz4;
  logic [63:0] par4, per4, t4;
  logic [30:0] np4, nq4;
  logic [31:0] dp4, dq4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (enable) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      diel4 <= diel3;
      eiz4  <= eiz3;
      par4  <= {1'b0, hi_ci3, 17'd0} + 64'(lo_ci3) + {10'd0, ct2_3, 24'd0};
      per4  <= {1'b0, hi_ct3, 17'd0} + 64'(lo_ct3) + {10'd0, ci2_3, 24'd0};
      t4    <= 64'(t3);
      np4   <= np3;
      nq4   <= nq3;
      dp4   <= dp3;
      dq4   <= dq3;
    end
  end

  // stage 5: pick the case, flag zero denominators
  logic [63:0] cdp, cdq;
  always_comb begin
    cdp = par4 + t4;
    cdq = per4 + t4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (enable) begin
      ctl.valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      ctl.dielectric <= diel4;
      if (diel4) begin
        ctl.degen <= eiz4 || (dp4 == 32'd0) || (dq4 == 32'd0);
        num_p <= 64'(np4);
        den_p <= 64'(dp4);
        num_q <= 64'(nq4);
        den_q <= 64'(dq4);
      end else begin
        ctl.degen <= (cdp == 64'd0) || (cdq == 64'd0);
        num_p <= (par4 >= t4) ? par4 - t4 : 64'd0;
        den_p <= cdp;
        num_q <= (per4 >= t4) ? per4 - t4 : 64'd0;
        den_q <= cdq;
      end
    end
  end
endmodule

// File: design/fru_divider.sv
// Two-lane pipelined restoring divider, one quotient bit per stage, Q0.31 result.
// Depends on fru_pkg.
module fru_divider import fru_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        enable,
  input  ctl_t        ctl_in,
  input  logic [63:0] num_p,
  input  logic [63:0] den_p,
  input  logic [63:0] num_q,
  input  logic [63:0] den_q,
  output ctl_t        ctl_out,
  output logic [31:0] ratio_p,
  output logic [31:0] ratio_q
);
  ctl_t        ctl_s [0:DivSteps];
  logic [63:0] rp [0:DivSteps];
  logic [63:0] rq [0:DivSteps];
  logic [63:0] dp [0:DivSteps];
  logic [63:0] dq [0:DivSteps];
  logic [30:0] qp [0:DivSteps];
  logic [30:0] qq [0:DivSteps];
  logic        sp [0:DivSteps];
  logic        sq [0:DivSteps];

  // entry stage: saturate when the ratio reaches 1.0
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s[0].valid <= 1'b0;
    end else if (enable) begin
      ctl_s[0].valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      ctl_s[0].dielectric <= ctl_in.dielectric;
      ctl_s[0].degen      <= ctl_in.degen;
      rp[0] <= num_p;
      rq[0] <= num_q;
      dp[0] <= den_p;
      dq[0] <= den_q;
      qp[0] <= '0;
      qq[0] <= '0;
      sp[0] <= (num_p >= den_p);
      sq[0] <= (num_q >= den_q);
    end
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic [64:0] rp2, rq2;
    always_comb begin
      rp2 = {rp[i], 1'b0};
      rq2 = {rq[i], 1'b0};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_s[i+1].valid <= 1'b0;
      end else if (enable) begin
        ctl_s[i+1].valid <= ctl_s[i].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (enable) begin
        ctl_s[i+1].dielectric <= ctl_s[i].dielectric;
        ctl_s[i+1].degen      <= ctl_s[i].degen;
        dp[i+1] <= dp[i];
        dq[i+1] <= dq[i];
        sp[i+1] <= sp[i];
        sq[i+1] <= sq[i];
        if (rp2 >= {1'b0, dp[i]}) begin
          rp[i+1] <= 64'(rp2 - {1'b0, dp[i]});
          qp[i+1] <= {qp[i][29:0], 1'b1};
        end else begin
          rp[i+1] <= rp2[63:0];
          qp[i+1] <= {qp[i][29:0], 1'b0};
        end
        if (rq2 >= {1'b0, dq[i]}) begin
          rq[i+1] <= 64'(rq2 - {1'b0, dq[i]});
          qq[i+1] <= {qq[i][29:0], 1'b1};
        end else begin
          rq[i+1] <= rq2[63:0];
          qq[i+1] <= {qq[i][29:0], 1'b0};
        end
      end
    end
  end

  assign ctl_out = ctl_s[DivSteps];
  assign ratio_p = sp[DivSteps] ? 32'h8000_0000 : {1'b0, qp[DivSteps]};
  assign ratio_q = sq[DivSteps] ? 32'h8000_0000 : {1'b0, qq[DivSteps]};
endmodule

// File: design/fru_back.sv
// Back stages: square or add the term ratios, round to Q0.16, saturate.
// Depends on fru_pkg.
module fru_back import fru_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        enable,
  input  ctl_t        ctl_in,
  input  logic [31:0] ratio_p,
  input  logic [31:0] ratio_q,
  output logic        out_valid,
  output logic [16:0] reflectance,
  output logic        degenerate
);
  ctl_t        ctl_a;
  logic [63:0] pp_a, qq_a;
  logic [32:0] sum_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a.valid <= 1'b0;
    end else if (enable) begin
      ctl_a.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      ctl_a.dielectric <= ctl_in.dielectric;
      ctl_a.degen      <= ctl_in.degen;
      pp_a  <= 64'(ratio_p) * 64'(ratio_p);
      qq_a  <= 64'(ratio_q) * 64'(ratio_q);
      sum_a <= 33'(ratio_p) + 33'(ratio_q);
    end
  end

  logic [64:0] dsum;
  logic [17:0] rnd;
  always_comb begin
    dsum = 65'(pp_a) + 65'(qq_a) + (65'd1 << 46);
    if (ctl_a.dielectric) begin
      rnd = 18'(dsum >> 47);
    end else begin
      rnd = 18'((34'(sum_a) + 34'h8000) >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (enable) begin
      out_valid <= ctl_a.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      degenerate  <= ctl_a.degen;
      reflectance <= (ctl_a.degen || rnd > 18'(ONE_OUT)) ? ONE_OUT : rnd[16:0];
    end
  end
endmodule

// File: design/fresnel_reflectance_unit.sv
// Fresnel reflectance unit: unpolarized reflectance, one sample per transaction.
// Pipeline stages: 5 front stages, 32 divider stages, 2 back stages.
// Throughput one transaction per cycle unless the output stalls; the 31-step divider pipeline sets the depth.
// Synchronous active-high rst clears every valid bit; payload registers keep no reset.
// Depends on fru_pkg, fru_front, fru_divider, fru_back and the assertion header.
`include "fresnel_reflectance_unit_assert.svh"
module fresnel_reflectance_unit import fru_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [14:0] cos_incident,
  input  logic [14:0] cos_transmitted,
  input  logic [15:0] eta_value,
  input  logic [15:0] eta_incident,
  input  logic [15:0] extinction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] reflectance,
  output logic        degenerate
);
  // Advance the whole pipeline together; hold it only while the output
  // register has a transaction that the consumer does not take.
  logic enable;
  assign enable   = !out_valid || out_ready;
  assign in_ready = enable;

  ctl_t        ctl_f, ctl_d;
  logic [63:0] num_p, den_p, num_q, den_q;
  logic [31:0] ratio_p, ratio_q;

  // Form both terms' numerator and denominator for the selected case.
  fru_front u_front (
    .clk, .rst, .enable, .in_valid,
    .func, .cos_incident, .cos_transmitted, .eta_value, .eta_incident, .extinction,
    .ctl(ctl_f), .num_p, .den_p, .num_q, .den_q
  );

  // Divide each term to Q0.31, one quotient bit per stage.
  fru_divider u_div (
    .clk, .rst, .enable, .ctl_in(ctl_f),
    .num_p, .den_p, .num_q, .den_q,
    .ctl_out(ctl_d), .ratio_p, .ratio_q
  );

  // Combine the terms, round and saturate.
  fru_back u_back (
    .clk, .rst, .enable, .ctl_in(ctl_d), .ratio_p, .ratio_q,
    .out_valid, .reflectance, .degenerate
  );

  `FRU_ASSERT(a_degen_full, out_valid && degenerate |-> reflectance == ONE_OUT)
  `FRU_ASSERT(a_range, out_valid |-> reflectance <= ONE_OUT)
  `FRU_ASSERT_RST(a_rst_clear, rst |=> !out_valid)
endmodule

// File: test/fresnel_reflectance_unit_tb.sv
// Testbench for the Fresnel reflectance unit: directed table, then random transactions.
// Results are checked field by field against a bit-exact predictor in this file.
// Depends on fru_pkg and the fresnel_reflectance_unit RTL.
module fresnel_reflectance_unit_tb;
  import fru_pkg::*;

  localparam int LATENCY   = 39;
  localparam int N_RANDOM  = 1830;
  localparam int CYCLE_CAP = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = '0;
  logic [14:0] cos_incident = '0;
  logic [14:0] cos_transmitted = '0;
  logic [15:0] eta_value = '0;
  logic [15:0] eta_incident = 16'd1;
  logic [15:0] extinction = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [16:0] reflectance;
  logic        degenerate;

  typedef struct packed {
    func_t       fn;
    logic [14:0] ci;
    logic [14:0] ct;
    logic [15:0] ev;
    logic [15:0] ei;
    logic [15:0] kk;
  } sample_t;

  typedef struct packed {
    logic [16:0] refl;
    logic        degen;
  } refl_t;

  // Directed row: the sample plus an optional typed-in expectation.
  typedef struct packed {
    sample_t smp;
    logic    known;
    refl_t   want;
  } row_t;

  refl_t pending_refl[$];
  int    failures = 0;
  int    cycles = 0;
  int    send_idle_pct = 16;
  int    recv_idle_pct = 61;
  bit    recv_hold = 1'b0;

  fresnel_reflectance_unit u_dut (.*);

  always #4 clk = ~clk;

  // Truncating Q0.31 quotient; saturates at 1.0 when num >= den.
  function automatic logic [63:0] frac_q31(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] gap;
    quo = 0;
    rem = num;
    if (num >= den) return 64'd1 << 31;
    for (int i = 0; i < 31; i++) begin
      gap = den - rem;
      if (rem >= gap) begin
        quo = (quo << 1) | 64'd1;
        rem = rem - gap;
      end else begin
        quo = quo << 1;
        rem = rem + rem;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] dist64(logic [63:0] a, logic [63:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic refl_t predict_reflectance(sample_t s);
    logic [63:0] ci, ct, ev, ei, kk;
    logic [63:0] a, b, c, d, p, q, sum, refl;
    logic [63:0] ss, ci2, ct2, t, par, per;
    logic        degen;
    refl_t       r;
    ci = s.ci; ct = s.ct; ev = s.ev; ei = s.ei; kk = s.kk;
    refl = 0;
    degen = 1'b0;
    if (s.fn == FUNC_DIEL_TWO || s.fn == FUNC_DIEL_RATIO) begin
      if (s.fn == FUNC_DIEL_RATIO) ei = ONE_ETA;
      if (ei == 0) begin
        degen = 1'b1;
      end else begin
        a = ei * ct; b = ev * ci; c = ei * ci; d = ev * ct;
        if (a + b == 0 || c + d == 0) begin
          degen = 1'b1;
        end else begin
          p = frac_q31(dist64(a, b), a + b);
          q = frac_q31(dist64(c, d), c + d);
          sum = p * p + q * q;
          refl = (sum + (64'd1 << 46)) >> 47;
        end
      end
    end else begin
      if (s.fn == FUNC_COND) ct = ONE_COS;
      ss = ev * ev + kk * kk;
      ci2 = ci * ci;
      ct2 = ct * ct;
      t = ((ev * ci * ct) << 1) << 12;
      par = ss * ci2 + (ct2 << 24);
      per = ss * ct2 + (ci2 << 24);
      if (par + t == 0 || per + t == 0) begin
        degen = 1'b1;
      end else begin
        p = frac_q31((par >= t) ? par - t : 0, par + t);
        q = frac_q31((per >= t) ? per - t : 0, per + t);
        sum = p + q;
        refl = (sum + (64'd1 << 15)) >> 16;
      end
    end
    if (degen || refl > ONE_OUT) refl = ONE_OUT;
    r.refl = refl[16:0];
    r.degen = degen;
    return r;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.fn = func_t'($urandom_range(3, 0));
    // Mostly in-range cosines, sometimes any 15-bit value.
    s.ci = ($urandom_range(9, 0) == 0) ? 15'($urandom) : 15'($urandom_range(16384, 0));
    s.ct = ($urandom_range(9, 0) == 0) ? 15'($urandom) : 15'($urandom_range(16384, 0));
    case ($urandom_range(3, 0))
      0: s.ev = 16'($urandom);
      1: s.ev = 16'($urandom_range(12288, 2048));
      default: s.ev = 16'($urandom_range(8192, 0));
    endcase
    s.ei = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(8192, 1));
    if ($urandom_range(49, 0) == 0) s.ei = '0;
    s.kk = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(20480, 0));
    if ($urandom_range(19, 0) == 0) s.ci = '0;
    if ($urandom_range(19, 0) == 0) s.ct = '0;
    if ($urandom_range(19, 0) == 0) s.ev = '0;
    return s;
  endfunction

  // Offer one transaction, hold it until accepted, queue its expectation.
  // Drop valid only while idling, so back-to-back transactions keep it high.
  task automatic send_sample(sample_t s, bit known, refl_t want);
    refl_t expd;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    func            <= s.fn;
    cos_incident    <= s.ci;
    cos_transmitted <= s.ct;
    eta_value       <= s.ev;
    eta_incident    <= s.ei;
    extinction      <= s.kk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expd = predict_reflectance(s);
    if (known && expd != want) begin
      $error("table row disagrees with predictor: refl exp %0d got %0d", want.refl, expd.refl);
      failures++;
    end
    pending_refl.push_back(known ? want : expd);
  endtask

  // Receiver: random stall unless held off for the long pressure stretch.
  always @(posedge clk) begin
    if (rst || recv_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Compare each completed transaction with the oldest expectation.
  always @(posedge clk) begin
    refl_t expd;
    if (!rst && out_valid && out_ready) begin
      if (pending_refl.size() == 0) begin
        $error("unexpected result: reflectance %0d degenerate %0d", reflectance, degenerate);
        failures++;
      end else begin
        expd = pending_refl.pop_front();
        if (reflectance !== expd.refl) begin
          $error("reflectance exp %0d got %0d", expd.refl, reflectance);
          failures++;
        end
        if (degenerate !== expd.degen) begin
          $error("degenerate exp %0d got %0d", expd.degen, degenerate);
          failures++;
        end
      end
    end
  end

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Long receiver hold-off while the sender keeps offering transactions.
  initial begin
    wait (!rst);
    repeat (300) @(posedge clk);
    recv_hold = 1'b1;
    repeat (200) @(posedge clk);
    recv_hold = 1'b0;
  end

  row_t dir_rows[$];

  function automatic row_t mk(func_t fn, int ci, int ct, int ev, int ei, int kk,
                              bit known, int refl, bit dg);
    row_t r;
    r.smp.fn = fn; r.smp.ci = 15'(ci); r.smp.ct = 15'(ct);
    r.smp.ev = 16'(ev); r.smp.ei = 16'(ei); r.smp.kk = 16'(kk);
    r.known = known; r.want.refl = 17'(refl); r.want.degen = dg;
    return r;
  endfunction

  initial begin
    refl_t none;
    none = '0;
    // A zero incident index, or zero cosines/indices that give a zero denominator: 1.0 with the flag.
    dir_rows.push_back(mk(FUNC_DIEL_TWO,   16384, 16384, 4096, 0,     0, 1, 65536, 1));
    dir_rows.push_back(mk(FUNC_DIEL_TWO,   0,     0,     4096, 4096,  0, 1, 65536, 1));
    dir_rows.push_back(mk(FUNC_DIEL_RATIO, 0,     0,     4096, 0,     0, 1, 65536, 1));
    dir_rows.push_back(mk(FUNC_COND,       0,     0,     0,    1,     0, 1, 65536, 1));
    dir_rows.push_back(mk(FUNC_COND_FULL,  0,     0,     0,    1,     0, 1, 65536, 1));
    // Matched indices at normal incidence: no reflection.
    dir_rows.push_back(mk(FUNC_DIEL_RATIO, 16384, 16384, 4096, 1,     0, 1, 0, 0));
    dir_rows.push_back(mk(FUNC_DIEL_TWO,   16384, 16384, 8192, 8192,  0, 1, 0, 0));
    // Zero ratio: total reflection without degeneracy.
    dir_rows.push_back(mk(FUNC_DIEL_RATIO, 16384, 16384, 0,    1,     0, 1, 65536, 0));
    // Field extremes and mid-range samples, checked by the predictor.
    dir_rows.push_back(mk(FUNC_DIEL_TWO,   32767, 32767, 65535, 65535, 65535, 0, 0, 0));
    dir_rows.push_back(mk(FUNC_DIEL_TWO,   32767, 1,     65535, 1,     0, 0, 0, 0));
    dir_rows.push_back(mk(FUNC_DIEL_RATIO, 1,     32767, 65535, 65535, 65535, 0, 0, 0));
    dir_rows.push_back(mk(FUNC_DIEL_RATIO, 11585, 8000,  6144,  4096,  0, 0, 0, 0));
    dir_rows.push_back(mk(FUNC_COND,       32767, 0,     65535, 65535, 65535, 0, 0, 0));
    dir_rows.push_back(mk(FUNC_COND,       16384, 5,     4096,  1,     0, 0, 0, 0));
    dir_rows.push_back(mk(FUNC_COND,       8192,  100,   800,   1,     12000, 0, 0, 0));
    dir_rows.push_back(mk(FUNC_COND_FULL,  32767, 32767, 65535, 65535, 65535, 0, 0, 0));
    dir_rows.push_back(mk(FUNC_COND_FULL,  16384, 16384, 4096,  1,     0, 0, 0, 0));
    dir_rows.push_back(mk(FUNC_COND_FULL,  0,     16384, 0,     1,     1, 0, 0, 0));
    dir_rows.push_back(mk(FUNC_COND_FULL,  12000, 9000,  700,   1,     14000, 0, 0, 0));
    dir_rows.push_back(mk(FUNC_COND_FULL,  16384, 0,     0,     1,     0, 0, 0, 0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_sample(dir_rows[i].smp, dir_rows[i].known, dir_rows[i].want);

    // Three idling phases: sender-light, receiver-light, none.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        send_idle_pct = 61; recv_idle_pct = 16;
      end else if (n == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      send_sample(random_sample(), 1'b0, none);
    end
    in_valid <= 1'b0;

    while (pending_refl.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
